// ===== hw/rtl/pip_pkg.sv =====
// ----------------------------------------------------------------------------
// Point-in-polygon package
// Shared sizes and operation codes for the point-in-polygon test block.
// ----------------------------------------------------------------------------
package pip_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_WIDTH  = 16;

  localparam int IDX_W  = $clog2(MAX_VERTICES);
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int PROD_W = 2 * DIFF_W;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

endpackage

// ===== hw/rtl/point_in_polygon_test.sv =====
// ----------------------------------------------------------------------------
// Point-in-polygon test
// Even-odd crossing test of a query point against a stored vertex list.
//
// A beat is accepted at a rising edge with start high and busy low. The beat
// carries operation, x and y: clear the vertex list, append one vertex, or
// query one point. Every beat gives one result beat: done is high for exactly
// one cycle with inside_res and status valid; the receiver cannot stall.
// Clear, append and unused codes answer in the cycle after acceptance and
// keep busy low, so such beats may follow back to back. An append to a full
// list is dropped and answers with status set.
// A query holds busy high through ST_PRE, ST_EDGE_A and ST_EDGE_B for each
// stored vertex, and ST_FIN; done rises in the first cycle with busy low. A
// query of an empty list keeps busy low and answers in the cycle after
// acceptance. The edge loop shares one signed multiplier: each edge uses it
// twice, once per cycle; the next edge's first cycle folds in its compare.
// Synchronous reset empties the vertex list and idles the block; the vertex
// memory itself is not cleared.
// ----------------------------------------------------------------------------
module point_in_polygon_test
  import pip_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    operation,
  input  logic signed [COORD_WIDTH-1:0] x,
  input  logic signed [COORD_WIDTH-1:0] y,
  output logic                          done,
  output logic                          inside_res,
  output logic                          status
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE,
    ST_EDGE_A,
    ST_EDGE_B,
    ST_FIN
  } state_t;

  state_t state;

  logic signed [COORD_WIDTH-1:0] mem_x [MAX_VERTICES];
  logic signed [COORD_WIDTH-1:0] mem_y [MAX_VERTICES];
  logic signed [COORD_WIDTH-1:0] rd_x, rd_y;
  logic                          rd_en;
  logic [IDX_W-1:0]              rd_addr;
  logic                          wr_en;

  logic [CNT_W-1:0]              vert_cnt;
  logic [CNT_W-1:0]              last_vertex;
  logic [IDX_W-1:0]              idx;
  logic signed [COORD_WIDTH-1:0] qx, qy;
  logic signed [COORD_WIDTH-1:0] px, py;
  logic signed [PROD_W-1:0]      lhs, rhs;
  logic                          e_straddle, e_dypos;
  logic                          in_flag;

  logic                          accept;
  logic signed [DIFF_W-1:0]      d_qo_x, d_po_y, d_po_x, d_qo_y;
  logic signed [DIFF_W-1:0]      mul_a, mul_b;
  logic signed [PROD_W-1:0]      mul_p;
  logic                          straddle, toggle;

  assign accept      = start && !busy;
  assign busy        = (state != ST_IDLE);
  assign last_vertex = vert_cnt - CNT_W'(1);
  assign wr_en       = accept && (operation == OP_APPEND)
                       && (vert_cnt < CNT_W'(MAX_VERTICES));

  // Edge from current vertex (rd_*) to previous vertex (p*)
  assign d_qo_x = DIFF_W'(qx) - DIFF_W'(rd_x);
  assign d_po_y = DIFF_W'(py) - DIFF_W'(rd_y);
  assign d_po_x = DIFF_W'(px) - DIFF_W'(rd_x);
  assign d_qo_y = DIFF_W'(qy) - DIFF_W'(rd_y);
  assign straddle = (rd_y > qy) != (py > qy);

  always_comb begin
    if (state == ST_EDGE_B) begin
      mul_a = d_po_x;
      mul_b = d_qo_y;
    end else begin
      mul_a = d_qo_x;
      mul_b = d_po_y;
    end
  end

  assign mul_p  = mul_a * mul_b;
  assign toggle = e_straddle && (e_dypos ? (lhs < rhs) : (rhs < lhs));

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    unique case (state)
      ST_IDLE: begin
        rd_en   = accept && (operation == OP_QUERY);
        rd_addr = last_vertex[IDX_W-1:0];
      end
      ST_PRE: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      ST_EDGE_B: begin
        rd_en   = ({1'b0, idx} != last_vertex);
        rd_addr = idx + IDX_W'(1);
      end
      default: begin
        rd_en   = 1'b0;
        rd_addr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[vert_cnt[IDX_W-1:0]] <= x;
      mem_y[vert_cnt[IDX_W-1:0]] <= y;
    end
    if (rd_en) begin
      rd_x <= mem_x[rd_addr];
      rd_y <= mem_y[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      vert_cnt   <= '0;
      done       <= 1'b0;
      inside_res <= 1'b0;
      status     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            inside_res <= 1'b0;
            status     <= 1'b0;
            unique case (operation)
              OP_CLEAR: begin
                vert_cnt <= '0;
                done     <= 1'b1;
              end
              OP_APPEND: begin
                if (wr_en) begin
                  vert_cnt <= vert_cnt + CNT_W'(1);
                end else begin
                  status <= 1'b1;
                end
                done <= 1'b1;
              end
              OP_QUERY: begin
                qx <= x;
                qy <= y;
                if (vert_cnt == '0) begin
                  done <= 1'b1;
                end else begin
                  state <= ST_PRE;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        ST_PRE: begin
          px         <= rd_x;
          py         <= rd_y;
          idx        <= '0;
          in_flag    <= 1'b0;
          e_straddle <= 1'b0;
          state      <= ST_EDGE_A;
        end
        ST_EDGE_A: begin
          in_flag    <= in_flag ^ toggle;
          lhs        <= mul_p;
          e_straddle <= straddle;
          e_dypos    <= (d_po_y > 0);
          state      <= ST_EDGE_B;
        end
        ST_EDGE_B: begin
          rhs <= mul_p;
          px  <= rd_x;
          py  <= rd_y;
          if ({1'b0, idx} == last_vertex) begin
            state <= ST_FIN;
          end else begin
            idx   <= idx + IDX_W'(1);
            state <= ST_EDGE_A;
          end
        end
        ST_FIN: begin
          inside_res <= in_flag ^ toggle;
          done       <= 1'b1;
          state      <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/pip_checker.sv =====
// ----------------------------------------------------------------------------
// Point-in-polygon checker
// Port-level timing checks for the point-in-polygon test block.
// ----------------------------------------------------------------------------
module pip_checker
  import pip_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] operation,
  input logic       done,
  input logic       inside_res,
  input logic       status
);

  a_quick_answer: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (operation != OP_QUERY)) |=> done)
    else $error("non-query beat not answered in next cycle");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (operation == OP_QUERY)) |=> (busy || done))
    else $error("query beat neither busy nor answered");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result while busy");

  a_busy_end: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy fell without result");

  a_status_excl: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> !inside_res)
    else $error("status and inside both set");

endmodule

bind point_in_polygon_test pip_checker u_pip_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .operation  (operation),
  .done       (done),
  .inside_res (inside_res),
  .status     (status)
);

// ===== test/point_in_polygon_test_tb.sv =====
// ----------------------------------------------------------------------------
// Point-in-polygon test bench
// Drives clear, append and query beats into point_in_polygon_test and checks
// every result beat against a local even-odd crossing predictor, or against
// a typed directed row's values. A short directed table covers the empty
// list, the coordinate extremes and points on edges and vertices. Random
// polygons of varied size and span follow, with overflowing appends, unused
// codes and broken sequences mixed in. The sender idles in random bursts.
// ----------------------------------------------------------------------------
module point_in_polygon_test_tb;
  import pip_pkg::*;

  localparam int ITEM_TARGET   = 1100;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int DIRECTED_ROWS = 26;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    logic in_poly;
    logic full;
  } answer_t;

  typedef struct {
    op_t op;
    int  px;
    int  py;
    bit  typed;
    bit  want_inside;
    bit  want_full;
  } step_t;

  logic   clk = 1'b0;
  logic   rst;
  logic   start;
  logic   busy;
  op_t    operation;
  coord_t x;
  coord_t y;
  logic   done;
  logic   inside_res;
  logic   status;

  coord_t  poly_x [MAX_VERTICES];
  coord_t  poly_y [MAX_VERTICES];
  int      poly_len;
  answer_t pending_answers [$];
  int      errors = 0;
  int      cycles = 0;
  int      items_sent = 0;
  int      burst_left = 0;
  step_t   directed_steps [DIRECTED_ROWS];

  point_in_polygon_test i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .operation  (operation),
    .x          (x),
    .y          (y),
    .done       (done),
    .inside_res (inside_res),
    .status     (status)
  );

  always #1 clk = ~clk;

  function automatic bit crossing_inside(coord_t qx, coord_t qy);
    bit     flip;
    int     j;
    longint ox, oy, px, py, dy, lhs, rhs;
    flip = 1'b0;
    j = poly_len - 1;
    for (int i = 0; i < poly_len; i++) begin
      ox = poly_x[i];
      oy = poly_y[i];
      px = poly_x[j];
      py = poly_y[j];
      if ((oy > qy) != (py > qy)) begin
        dy  = py - oy;
        lhs = (qx - ox) * dy;
        rhs = (px - ox) * (qy - oy);
        if (dy > 0 ? lhs < rhs : rhs < lhs) flip = ~flip;
      end
      j = i;
    end
    return flip;
  endfunction

  function automatic answer_t polygon_step(op_t op, coord_t cx, coord_t cy);
    answer_t a;
    a = '0;
    case (op)
      OP_CLEAR: begin
        poly_len = 0;
      end
      OP_APPEND: begin
        if (poly_len >= MAX_VERTICES) begin
          a.full = 1'b1;
        end else begin
          poly_x[poly_len] = cx;
          poly_y[poly_len] = cy;
          poly_len++;
        end
      end
      OP_QUERY: begin
        a.in_poly = crossing_inside(cx, cy);
      end
      default: begin
      end
    endcase
    return a;
  endfunction

  function automatic coord_t rand_coord(int span);
    case (span)
      0:       return coord_t'($urandom);
      1:       return coord_t'(int'($urandom_range(0, 16)) - 8);
      default: return coord_t'(int'($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  task automatic issue(op_t op, coord_t cx, coord_t cy, bit typed, answer_t want);
    answer_t a;
    int      gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    start     <= 1'b1;
    operation <= op;
    x         <= cx;
    y         <= cy;
    do @(posedge clk); while (busy !== 1'b0);
    a = polygon_step(op, cx, cy);
    pending_answers.push_back(typed ? want : a);
    if (op != OP_NONE) items_sent++;
  endtask

  task automatic issue_query(int span);
    int     kind;
    int     i;
    int     j;
    coord_t qx;
    coord_t qy;
    kind = $urandom_range(0, 9);
    qx = rand_coord(span);
    qy = rand_coord(span);
    if (poly_len > 0 && kind >= 4 && kind <= 8) begin
      i = $urandom_range(0, poly_len - 1);
      j = (i == 0) ? poly_len - 1 : i - 1;
      case (kind)
        4, 5: begin
          qx = poly_x[i];
          qy = poly_y[i];
        end
        6: begin
          qy = poly_y[i];
        end
        default: begin
          qx = coord_t'((int'(poly_x[i]) + int'(poly_x[j])) / 2);
          qy = coord_t'((int'(poly_y[i]) + int'(poly_y[j])) / 2);
        end
      endcase
    end else if (kind == 9) begin
      qx = rand_coord(0);
      qy = rand_coord(0);
    end
    issue(OP_QUERY, qx, qy, 1'b0, '0);
  endtask

  always @(posedge clk) begin : check_answers
    answer_t exp_a;
    if (!rst && done === 1'b1) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result beat: inside_res=%b status=%b",
                 $time, inside_res, status);
        errors++;
      end else begin
        exp_a = pending_answers.pop_front();
        if (inside_res !== exp_a.in_poly) begin
          $display("%0t: inside_res mismatch: expected %b actual %b",
                   $time, exp_a.in_poly, inside_res);
          errors++;
        end
        if (status !== exp_a.full) begin
          $display("%0t: status mismatch: expected %b actual %b",
                   $time, exp_a.full, status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("point_in_polygon_test test failed");
      $finish;
    end
  end

  initial begin
    int span;
    int nverts;
    int nq;
    int r;
    rst       = 1'b1;
    start     = 1'b0;
    operation = OP_CLEAR;
    x         = '0;
    y         = '0;
    poly_len  = 0;

    directed_steps = '{
      '{OP_QUERY,       0,      0, 1'b1, 1'b0, 1'b0},
      '{OP_NONE,       -1,     -1, 1'b1, 1'b0, 1'b0},
      '{OP_APPEND, -32768, -32768, 1'b1, 1'b0, 1'b0},
      '{OP_QUERY,       0,      0, 1'b1, 1'b0, 1'b0},
      '{OP_QUERY,  -32768, -32768, 1'b1, 1'b0, 1'b0},
      '{OP_APPEND,  32767, -32768, 1'b1, 1'b0, 1'b0},
      '{OP_QUERY,       0,      0, 1'b0, 1'b0, 1'b0},
      '{OP_APPEND,  32767,  32767, 1'b1, 1'b0, 1'b0},
      '{OP_APPEND, -32768,  32767, 1'b1, 1'b0, 1'b0},
      '{OP_QUERY,       0,      0, 1'b0, 1'b0, 1'b0},
      '{OP_QUERY,  -32768, -32768, 1'b0, 1'b0, 1'b0},
      '{OP_QUERY,   32767,  32767, 1'b0, 1'b0, 1'b0},
      '{OP_QUERY,  -32768,      0, 1'b0, 1'b0, 1'b0},
      '{OP_QUERY,   32767,      0, 1'b0, 1'b0, 1'b0},
      '{OP_QUERY,       0, -32768, 1'b0, 1'b0, 1'b0},
      '{OP_QUERY,      -1,  32767, 1'b0, 1'b0, 1'b0},
      '{OP_NONE,    32767, -32768, 1'b1, 1'b0, 1'b0},
      '{OP_CLEAR,  -32768,  32767, 1'b1, 1'b0, 1'b0},
      '{OP_QUERY,       0,      0, 1'b1, 1'b0, 1'b0},
      '{OP_APPEND,      0,      0, 1'b1, 1'b0, 1'b0},
      '{OP_APPEND,      4,      8, 1'b1, 1'b0, 1'b0},
      '{OP_APPEND,      8,      0, 1'b1, 1'b0, 1'b0},
      '{OP_QUERY,       4,      4, 1'b0, 1'b0, 1'b0},
      '{OP_QUERY,       4,      0, 1'b0, 1'b0, 1'b0},
      '{OP_QUERY,       2,      4, 1'b0, 1'b0, 1'b0},
      '{OP_QUERY,       6,      4, 1'b0, 1'b0, 1'b0}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_steps[k]) begin
      issue(directed_steps[k].op, coord_t'(directed_steps[k].px),
            coord_t'(directed_steps[k].py), directed_steps[k].typed,
            '{directed_steps[k].want_inside, directed_steps[k].want_full});
    end

    // random polygons; some overfill the list, some stay degenerate
    while (items_sent < ITEM_TARGET) begin
      span = $urandom_range(0, 2);
      r = $urandom_range(0, 9);
      if (r == 0) nverts = $urandom_range(60, 68);
      else if (r == 1) nverts = $urandom_range(0, 2);
      else nverts = $urandom_range(3, 10);
      if ($urandom_range(0, 9) != 0) issue(OP_CLEAR, rand_coord(0), rand_coord(0), 1'b0, '0);
      for (int v = 0; v < nverts; v++) begin
        r = $urandom_range(0, 19);
        if (r == 0) issue(OP_NONE, rand_coord(0), rand_coord(0), 1'b0, '0);
        else if (r == 1) issue(op_t'($urandom_range(0, 3)), rand_coord(0), rand_coord(0),
                               1'b0, '0);
        else if (r == 2) issue_query(span);
        issue(OP_APPEND, rand_coord(span), rand_coord(span), 1'b0, '0);
      end
      nq = $urandom_range(1, 8);
      for (int q = 0; q < nq; q++) issue_query(span);
    end

    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (2 * MAX_VERTICES + 8) @(posedge clk);
    if (errors == 0) begin
      $display("point_in_polygon_test test passed");
    end else begin
      $display("point_in_polygon_test test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/pip_pkg.sv
hw/rtl/point_in_polygon_test.sv
hw/rtl/pip_checker.sv
test/point_in_polygon_test_tb.sv
